// ===== rtl/core/bmf2d_pkg.sv =====
// Package: word types, register indexes and divider constants for the box mean filter.
`timescale 1ns / 1ps
`default_nettype none
package bmf2d_pkg;

	localparam int unsigned KS_W        = 4;
	localparam int unsigned DIM_W       = 12;
	localparam int unsigned POS_W       = 23;
	localparam int unsigned LAT_W       = 15;
	localparam int unsigned SUM_W       = 16;
	localparam int unsigned RECIP_W     = 25;
	localparam int unsigned RECIP_SHIFT = 24;
	localparam int unsigned MAX_HEIGHT  = 2048;

	localparam logic [1:0] CFG_KERNEL = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] pixel_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       frame_end;
	} out_word_t;

	// work handed from front to back
	typedef struct packed {
		logic             wr;
		logic [7:0]       pix;
		logic             has_out;
		logic [KS_W-1:0]  side;
		logic [DIM_W-1:0] step;
		logic             frame_end;
	} meta_t;

	// floor(2^24 / (n*n)) for odd n
	function automatic logic [RECIP_W-1:0] recip_f(input logic [KS_W-1:0] n);
		logic [RECIP_W-1:0] r;
		case (n)
			4'd3:    r = 25'd1864135;
			4'd5:    r = 25'd671088;
			4'd7:    r = 25'd342392;
			4'd9:    r = 25'd207126;
			4'd11:   r = 25'd138654;
			4'd13:   r = 25'd99273;
			4'd15:   r = 25'd74565;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bmf2d_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bmf2d_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/bmf2d_fifo.sv =====
// Short register queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module bmf2d_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;

	assign full  = (cnt_q == (PW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue underflow");

endmodule
`default_nettype wire

// ===== rtl/core/bmf2d_front.sv =====
// Front end: config registers, frame position tracking and item classification.
`timescale 1ns / 1ps
`default_nettype none
module bmf2d_front #(
	parameter int unsigned MAX_KERNEL = 15,
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned RING       = 30735,
	parameter int unsigned ADDR_W     = 15
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [11:0]              cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire bmf2d_pkg::in_word_t      in_data,
	input  wire logic                     q_full,
	output logic                          q_push,
	output bmf2d_pkg::meta_t              q_meta,
	output logic      [ADDR_W-1:0]        q_waddr,
	output logic      [ADDR_W-1:0]        q_base
);

	localparam int unsigned K_TOP = (MAX_KERNEL - 1) | 1;
	localparam int unsigned DW    = bmf2d_pkg::DIM_W;
	localparam int unsigned PW    = bmf2d_pkg::POS_W;
	localparam int unsigned LW    = bmf2d_pkg::LAT_W;

	function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] a);
		return (a == ADDR_W'(RING - 1)) ? '0 : a + 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] ring_sub(input logic [ADDR_W-1:0] a,
			input logic [ADDR_W-1:0] b);
		logic [ADDR_W:0] s;
		if (a >= b) begin
			s = {1'b0, a} - {1'b0, b};
		end else begin
			s = {1'b0, a} + (ADDR_W+1)'(RING) - {1'b0, b};
		end
		return s[ADDR_W-1:0];
	endfunction

	logic [bmf2d_pkg::KS_W-1:0] ks_q;
	logic [DW-1:0]              fw_q, fh_q;
	logic [DW-1:0]              col_q, row_q, ocol_q, orow_q;
	logic [PW-1:0]              pos_q, oidx_q;
	logic [ADDR_W-1:0]          wptr_q, rptr_q;

	logic [bmf2d_pkg::KS_W-1:0] k;
	logic [2:0]                 adj;
	logic [DW-1:0]              w, h;
	logic [LW-1:0]              lat;
	logic [PW-1:0]              total;
	logic                       restart, accept, has_out, interior, cfg_hit;
	logic [DW-1:0]              col, row, oc, orw;
	logic [PW-1:0]              pos, oi;
	logic [ADDR_W-1:0]          wp, rp;

	always_comb begin
		k = ((32'(ks_q) > K_TOP) ? bmf2d_pkg::KS_W'(K_TOP) : ks_q) | 4'd1;
		adj = k[3:1];
		if (fw_q == '0) begin
			w = DW'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			w = DW'(MAX_WIDTH);
		end else begin
			w = fw_q;
		end
		if (fh_q == '0) begin
			h = DW'(1);
		end else if (32'(fh_q) > bmf2d_pkg::MAX_HEIGHT) begin
			h = DW'(bmf2d_pkg::MAX_HEIGHT);
		end else begin
			h = fh_q;
		end
		lat   = LW'(adj) * LW'(w) + LW'(adj);
		total = PW'(w) * PW'(h);
	end

	always_comb begin
		accept  = in_valid && in_ready;
		restart = !in_data.kind && (row_q >= h);
		col     = restart ? '0 : col_q;
		row     = restart ? '0 : row_q;
		pos     = restart ? '0 : pos_q;
		wp      = restart ? '0 : wptr_q;
		oi      = restart ? '0 : oidx_q;
		oc      = restart ? '0 : ocol_q;
		orw     = restart ? '0 : orow_q;
		rp      = restart ? '0 : rptr_q;
		if (in_data.kind) begin
			has_out = (row_q >= h) && (oidx_q < total);
		end else begin
			has_out = (pos >= PW'(lat));
		end
		interior = (orw >= DW'(adj)) && ({1'b0, orw} + 13'(adj) < {1'b0, h}) &&
			(oc >= DW'(adj)) && ({1'b0, oc} + 13'(adj) < {1'b0, w});
		cfg_hit = cfg_we && (cfg_index == bmf2d_pkg::CFG_KERNEL ||
			cfg_index == bmf2d_pkg::CFG_WIDTH || cfg_index == bmf2d_pkg::CFG_HEIGHT);
	end

	assign in_ready = !q_full;
	assign q_push   = accept && (!in_data.kind || has_out);

	always_comb begin
		q_meta.wr        = !in_data.kind;
		q_meta.pix       = in_data.pixel_in;
		q_meta.has_out   = has_out;
		q_meta.side      = interior ? k : 4'd1;
		q_meta.step      = w - DW'(q_meta.side) + DW'(1);
		q_meta.frame_end = ((oi + 1'b1) == total);
		q_waddr          = wp;
		q_base           = interior ? ring_sub(rp, ADDR_W'(lat)) : rp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q   <= 4'd3;
			fw_q   <= 12'd640;
			fh_q   <= 12'd480;
			col_q  <= '0;
			row_q  <= '0;
			pos_q  <= '0;
			wptr_q <= '0;
			oidx_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			rptr_q <= '0;
		end else if (cfg_hit) begin
			case (cfg_index)
				bmf2d_pkg::CFG_KERNEL: ks_q <= cfg_data[3:0];
				bmf2d_pkg::CFG_WIDTH:  fw_q <= cfg_data;
				bmf2d_pkg::CFG_HEIGHT: fh_q <= cfg_data;
				default: ;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			pos_q  <= '0;
			wptr_q <= '0;
			oidx_q <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			rptr_q <= '0;
		end else if (accept) begin
			if (!in_data.kind) begin
				pos_q  <= pos + 1'b1;
				wptr_q <= ring_inc(wp);
				if (col + 1'b1 >= w) begin
					col_q <= '0;
					row_q <= row + 1'b1;
				end else begin
					col_q <= col + 1'b1;
					row_q <= row;
				end
			end
			if (restart && !has_out) begin
				oidx_q <= '0;
				ocol_q <= '0;
				orow_q <= '0;
				rptr_q <= '0;
			end else if (has_out) begin
				oidx_q <= oi + 1'b1;
				rptr_q <= ring_inc(rp);
				if (oc + 1'b1 >= w) begin
					ocol_q <= '0;
					orow_q <= orw + 1'b1;
				end else begin
					ocol_q <= oc + 1'b1;
					orow_q <= orw;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/bmf2d_back.sv =====
// Back end: pixel store, window accumulation over the RAM port, divide and output register.
`timescale 1ns / 1ps
`default_nettype none
module bmf2d_back #(
	parameter int unsigned RING   = 30735,
	parameter int unsigned ADDR_W = 15
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   q_empty,
	output logic                        q_pop,
	input  wire bmf2d_pkg::meta_t       q_meta,
	input  wire logic [ADDR_W-1:0]      q_waddr,
	input  wire logic [ADDR_W-1:0]      q_base,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output bmf2d_pkg::out_word_t        out_data
);

	localparam int unsigned SW = bmf2d_pkg::SUM_W;
	localparam int unsigned RW = bmf2d_pkg::RECIP_W;

	typedef enum logic [2:0] {
		S_IDLE, S_WRITE, S_READ, S_DRAIN, S_DIV1, S_DIV2, S_DIV3, S_OUT
	} state_t;

	function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
			input logic [ADDR_W-1:0] b);
		logic [ADDR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (ADDR_W+1)'(RING)) begin
			s = s - (ADDR_W+1)'(RING);
		end
		return s[ADDR_W-1:0];
	endfunction

	state_t                       state_q;
	bmf2d_pkg::meta_t             cur_q;
	logic [ADDR_W-1:0]            waddr_q, raddr_q;
	logic [bmf2d_pkg::KS_W-1:0]   x_q, y_q;
	logic                         rd_pend_q;
	logic [SW-1:0]                sum_q;
	logic [SW+RW-1:0]             prod_q;
	logic [SW-1:0]                qe_q;
	logic [SW+7:0]                qd_q;
	logic [7:0]                   res_q;
	logic                         out_valid_q;
	bmf2d_pkg::out_word_t         out_q;

	logic [7:0]                   rdata, dd;
	logic [SW-1:0]                qe, rem;

	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign dd    = 8'(cur_q.side) * 8'(cur_q.side);
	assign qe    = prod_q[bmf2d_pkg::RECIP_SHIFT +: SW];
	assign rem   = sum_q - SW'(qd_q);

	bmf2d_ram #(.WIDTH(8), .DEPTH(RING)) u_ram (
		.clk  (clk),
		.we   (state_q == S_WRITE && cur_q.wr),
		.waddr(waddr_q),
		.wdata(cur_q.pix),
		.raddr(raddr_q),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			rd_pend_q   <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == S_READ);
			if (rd_pend_q) begin
				sum_q <= sum_q + SW'(rdata);
			end
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						cur_q   <= q_meta;
						waddr_q <= q_waddr;
						raddr_q <= q_base;
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					x_q     <= '0;
					y_q     <= '0;
					sum_q   <= '0;
					state_q <= cur_q.has_out ? S_READ : S_IDLE;
				end
				S_READ: begin
					if (x_q == cur_q.side - 1'b1) begin
						x_q <= '0;
						if (y_q == cur_q.side - 1'b1) begin
							state_q <= S_DRAIN;
						end else begin
							y_q     <= y_q + 1'b1;
							raddr_q <= ring_add(raddr_q, ADDR_W'(cur_q.step));
						end
					end else begin
						x_q     <= x_q + 1'b1;
						raddr_q <= ring_add(raddr_q, ADDR_W'(1));
					end
				end
				S_DRAIN: state_q <= S_DIV1;
				S_DIV1: begin
					prod_q  <= (SW+RW)'(sum_q) * (SW+RW)'(bmf2d_pkg::recip_f(cur_q.side));
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					qe_q    <= qe;
					qd_q    <= (SW+8)'(qe) * (SW+8)'(dd);
					state_q <= S_DIV3;
				end
				S_DIV3: begin
					res_q   <= (rem >= SW'(dd)) ? 8'(qe_q + 1'b1) : 8'(qe_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q.pixel_out <= res_q;
						out_q.frame_end <= cur_q.frame_end;
						out_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_one_correction: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV3 |-> rem < {SW'(dd), 1'b0})
		else $error("reciprocal estimate off by more than one");
	a_read_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> cur_q.has_out)
		else $error("window read for an item without result");
	a_pop_to_write: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == S_WRITE)
		else $error("popped word not taken");

endmodule
`default_nettype wire

// ===== rtl/core/box_mean_filter_2d_top.sv =====
// Top level of the k-by-k box mean filter: front end, queue and back end.
//
//  channel | dir | handshake          | word
//  in      | in  | in_valid/in_ready  | in_data  (kind, pixel_in)
//  out     | out | out_valid/out_ready| out_data (pixel_out, frame_end)
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
//
// A word with no result only passes the back end's write state. One with a result
// also goes through window read, drain, DIV1 to DIV3 and output; its n-by-n window
// (n = k inside, 1 on the border) is read one pixel per cycle on the single RAM read port.
// The front takes a word each cycle while the two-entry queue has room.
// Reset is asynchronous; the pixel RAM has no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module box_mean_filter_2d_top #(
	parameter int unsigned MAX_KERNEL = 15,
	parameter int unsigned MAX_WIDTH  = 2048
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [11:0]           cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire bmf2d_pkg::in_word_t   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output bmf2d_pkg::out_word_t       out_data
);

	localparam int unsigned RING   = MAX_KERNEL * MAX_WIDTH + MAX_KERNEL;
	localparam int unsigned ADDR_W = $clog2(RING);
	localparam int unsigned QW     = $bits(bmf2d_pkg::meta_t) + 2 * ADDR_W;

	logic                  q_push, q_pop, q_full, q_empty;
	bmf2d_pkg::meta_t      f_meta, b_meta;
	logic [ADDR_W-1:0]     f_waddr, f_base, b_waddr, b_base;
	logic [QW-1:0]         q_rdata;

	bmf2d_front #(
		.MAX_KERNEL(MAX_KERNEL), .MAX_WIDTH(MAX_WIDTH), .RING(RING), .ADDR_W(ADDR_W)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.q_full(q_full), .q_push(q_push),
		.q_meta(f_meta), .q_waddr(f_waddr), .q_base(f_base)
	);

	bmf2d_fifo #(.WIDTH(QW), .DEPTH(2)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wdata({f_meta, f_waddr, f_base}),
		.pop(q_pop), .rdata(q_rdata),
		.full(q_full), .empty(q_empty)
	);

	assign {b_meta, b_waddr, b_base} = q_rdata;

	bmf2d_back #(.RING(RING), .ADDR_W(ADDR_W)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_pop(q_pop),
		.q_meta(b_meta), .q_waddr(b_waddr), .q_base(b_base),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule
`default_nettype wire
